/* rtl/assert_macros.svh */
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMQ_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`endif

/* rtl/rmq_pkg.sv */
// Shared widths, types and helpers for the rotation matrix to quaternion block.
// No dependencies.
`default_nettype none
package rmq_pkg;
  localparam int DW     = 16;
  localparam int FB     = 14;
  localparam int AW     = DW + 3;
  localparam int RSTEPS = (DW + FB + 3) / 2;
  localparam int RADW   = 2 * RSTEPS;
  localparam int NW     = DW + 1;
  localparam int NDW    = NW + FB + 1;
  localparam int DVW    = RSTEPS + 1;
  localparam int QW     = DW;
  localparam int REMW   = DVW + 1;
  localparam int CW     = NDW + DVW + QW;
  localparam int LANES  = 3;

  typedef enum logic [1:0] {
    QS_S = 2'd0,
    QS_X = 2'd1,
    QS_Y = 2'd2,
    QS_Z = 2'd3
  } qsel_t;

  typedef struct packed {
    qsel_t                     qsel;
    logic [LANES-1:0][NW-1:0]  num;
  } side_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [QW-1:0]   low;
    logic [QW-1:0]   q;
    logic            ovf;
    logic            neg;
    logic            nz;
  } lane_t;

  function automatic logic signed [AW-1:0] sx(input logic signed [DW-1:0] v);
    return {{(AW-DW){v[DW-1]}}, v};
  endfunction
endpackage
`default_nettype wire

/* rtl/rmq_front.sv */
// Input stage: trace test, case selection, root argument and numerators.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    vld_i,
  input  wire logic signed [rmq_pkg::DW-1:0] e00,
  input  wire logic signed [rmq_pkg::DW-1:0] e10,
  input  wire logic signed [rmq_pkg::DW-1:0] e20,
  input  wire logic signed [rmq_pkg::DW-1:0] e01,
  input  wire logic signed [rmq_pkg::DW-1:0] e11,
  input  wire logic signed [rmq_pkg::DW-1:0] e21,
  input  wire logic signed [rmq_pkg::DW-1:0] e02,
  input  wire logic signed [rmq_pkg::DW-1:0] e12,
  input  wire logic signed [rmq_pkg::DW-1:0] e22,
  output logic                         vld_o,
  output logic [rmq_pkg::RADW-1:0]     rad_o,
  output rmq_pkg::side_t               side_o
);
  import rmq_pkg::*;

  logic signed [AW-1:0] a00, a10, a20, a01, a11, a21, a02, a12, a22, one, t, arg;
  logic signed [AW-1:0] d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;
  logic                 vld_r;
  logic [RADW-1:0]      rad_r, rad_nxt;
  side_t                side_r, side_nxt;

  always_comb begin
    a00 = sx(e00); a10 = sx(e10); a20 = sx(e20);
    a01 = sx(e01); a11 = sx(e11); a21 = sx(e21);
    a02 = sx(e02); a12 = sx(e12); a22 = sx(e22);
    one = AW'(1) <<< FB;
    t = one + a00 + a11 + a22;
    d21m12 = a21 - a12;
    d02m20 = a02 - a20;
    d10m01 = a10 - a01;
    s10p01 = a10 + a01;
    s02p20 = a02 + a20;
    s21p12 = a21 + a12;
    if (t > AW'(1)) begin
      arg = t;
      side_nxt.qsel = QS_S;
      side_nxt.num = {d10m01[NW-1:0], d02m20[NW-1:0], d21m12[NW-1:0]};
    end else if (a00 > a11 && a00 > a22) begin
      arg = one + a00 - a11 - a22;
      side_nxt.qsel = QS_X;
      side_nxt.num = {s02p20[NW-1:0], s10p01[NW-1:0], d21m12[NW-1:0]};
    end else if (a11 > a22) begin
      arg = one + a11 - a00 - a22;
      side_nxt.qsel = QS_Y;
      side_nxt.num = {s21p12[NW-1:0], s10p01[NW-1:0], d02m20[NW-1:0]};
    end else begin
      arg = one + a22 - a00 - a11;
      side_nxt.qsel = QS_Z;
      side_nxt.num = {s21p12[NW-1:0], s02p20[NW-1:0], d10m01[NW-1:0]};
    end
    if (arg <= 0) begin
      rad_nxt = '0;
    end else begin
      rad_nxt = {arg[RADW-FB-1:0], {FB{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      side_r <= side_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

/* rtl/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic [rmq_pkg::RADW-1:0] rad_i,
  input  wire rmq_pkg::side_t        side_i,
  output logic                       vld_o,
  output logic [rmq_pkg::RSTEPS-1:0] root_o,
  output rmq_pkg::side_t             side_o
);
  import rmq_pkg::*;

  logic [RSTEPS-1:0]           vld_r;
  logic [RSTEPS-1:0][RADW-1:0] rem_r, root_r;
  side_t                       side_r [RSTEPS];

  for (genvar i = 0; i < RSTEPS; i++) begin : g_stage
    localparam logic [RADW-1:0] BIT = {{(RADW-1){1'b0}}, 1'b1} << (2 * (RSTEPS - 1 - i));
    logic [RADW-1:0] rem_in, root_in, rem_nxt, root_nxt;
    logic [RADW:0]   trial;
    logic            vld_in;
    side_t           side_in;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign vld_in  = vld_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial = {1'b0, root_in} + {1'b0, BIT};
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt  = rem_in - trial[RADW-1:0];
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[RSTEPS-1];
  assign root_o = root_r[RSTEPS-1][RSTEPS-1:0];
  assign side_o = side_r[RSTEPS-1];
endmodule
`default_nettype wire

/* rtl/rmq_div.sv */
// Pipelined rounding divider, three lanes sharing one divisor 2R.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic [rmq_pkg::RSTEPS-1:0] root_i,
  input  wire rmq_pkg::side_t        side_i,
  output logic                       vld_o,
  output logic [rmq_pkg::RSTEPS-1:0] root_o,
  output rmq_pkg::qsel_t             qsel_o,
  output rmq_pkg::lane_t [rmq_pkg::LANES-1:0] lane_o
);
  import rmq_pkg::*;

  localparam int NST = QW + 1;

  logic [NST-1:0]                   vld_r;
  logic [NST-1:0][RSTEPS-1:0]       root_r;
  qsel_t                            qsel_r [NST];
  lane_t [NST-1:0][LANES-1:0]       lane_r;
  lane_t [LANES-1:0]                pre_nxt;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic signed [NW-1:0] n;
      logic [NW-1:0]        mag;
      logic [NDW-1:0]       big;
      logic [DVW-1:0]       dv;
      n   = $signed(side_i.num[k]);
      mag = n[NW-1] ? NW'(-n) : NW'(n);
      dv  = {root_i, 1'b0};
      big = (NDW'(mag) << FB) + NDW'(root_i);
      pre_nxt[k].rem = REMW'(big >> QW);
      pre_nxt[k].low = big[QW-1:0];
      pre_nxt[k].q   = '0;
      pre_nxt[k].ovf = CW'(big) >= (CW'(dv) << QW);
      pre_nxt[k].neg = n[NW-1];
      pre_nxt[k].nz  = n != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r[0] <= root_i;
      qsel_r[0] <= side_i.qsel;
      lane_r[0] <= pre_nxt;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_stage
    lane_t [LANES-1:0] lane_nxt;
    logic  [DVW-1:0]   dv;

    always_comb begin
      dv = {root_r[j-1], 1'b0};
      for (int k = 0; k < LANES; k++) begin
        logic [REMW-1:0] sh;
        lane_nxt[k] = lane_r[j-1][k];
        sh = {lane_r[j-1][k].rem[REMW-2:0], lane_r[j-1][k].low[QW-j]};
        if (sh >= REMW'(dv)) begin
          lane_nxt[k].rem = sh - REMW'(dv);
          lane_nxt[k].q   = {lane_r[j-1][k].q[QW-2:0], 1'b1};
        end else begin
          lane_nxt[k].rem = sh;
          lane_nxt[k].q   = {lane_r[j-1][k].q[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= root_r[j-1];
        qsel_r[j] <= qsel_r[j-1];
        lane_r[j] <= lane_nxt;
      end
    end
  end

  assign vld_o  = vld_r[NST-1];
  assign root_o = root_r[NST-1];
  assign qsel_o = qsel_r[NST-1];
  assign lane_o = lane_r[NST-1];
endmodule
`default_nettype wire

/* rtl/rotation_matrix_to_quaternion_top.sv */
// Rotation matrix to unit quaternion, four-case trace method, Q1.14 fixed point.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries the nine matrix elements of one
//   request; output channel out_valid/out_ready carries q_scalar, q_x, q_y, q_z.
//   The pipeline has one input stage, 16 square root stages (one root bit
//   each), one divider setup stage, 16 divider stages (one quotient bit each) and
//   the output register. Throughput is one request per cycle when not stalled.
//   All stages advance together on one enable; in_ready is high whenever the
//   output register is empty or being taken. When the receiver stalls, the whole
//   pipeline holds in place and in_ready drops; nothing is lost or repeated.
//   Synchronous active-low reset clears every valid bit; data registers are not
//   reset. There is no configuration and no state between requests.
//   Non-rotation inputs that give a nonpositive root argument produce a zero root
//   and saturated quotients, or zero quotients where the numerator is zero.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r0_c0,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r1_c0,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r2_c0,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r0_c1,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r1_c1,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r2_c1,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r0_c2,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r1_c2,
  input  wire logic signed [rmq_pkg::DW-1:0] in_a_r2_c2,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [rmq_pkg::DW-1:0]    out_q_scalar,
  output logic signed [rmq_pkg::DW-1:0]    out_q_x,
  output logic signed [rmq_pkg::DW-1:0]    out_q_y,
  output logic signed [rmq_pkg::DW-1:0]    out_q_z
);
  import rmq_pkg::*;

  localparam logic [DW-1:0]   VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]   VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QW:0]     QLIM = {2'b01, {(QW-1){1'b0}}};

  logic                  en;
  logic                  f_vld, s_vld, d_vld;
  logic [RADW-1:0]       f_rad;
  side_t                 f_side, s_side;
  logic [RSTEPS-1:0]     s_root, d_root;
  qsel_t                 d_qsel;
  lane_t [LANES-1:0]     d_lane;
  logic                  vld_r;
  logic [3:0][DW-1:0]    comp_r, comp_nxt;
  logic                  all_neg;

  assign en       = !vld_r || out_ready;
  assign in_ready = en;

  rmq_front u_front (
    .clk, .rst_n, .en,
    .vld_i (in_valid),
    .e00 (in_a_r0_c0), .e10 (in_a_r1_c0), .e20 (in_a_r2_c0),
    .e01 (in_a_r0_c1), .e11 (in_a_r1_c1), .e21 (in_a_r2_c1),
    .e02 (in_a_r0_c2), .e12 (in_a_r1_c2), .e22 (in_a_r2_c2),
    .vld_o (f_vld), .rad_o (f_rad), .side_o (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .vld_i (f_vld), .rad_i (f_rad), .side_i (f_side),
    .vld_o (s_vld), .root_o (s_root), .side_o (s_side)
  );

  rmq_div u_div (
    .clk, .rst_n, .en,
    .vld_i (s_vld), .root_i (s_root), .side_i (s_side),
    .vld_o (d_vld), .root_o (d_root), .qsel_o (d_qsel), .lane_o (d_lane)
  );

  always_comb begin
    logic [RSTEPS:0] qt;
    logic [DW-1:0]   lv [LANES];
    qt = ({1'b0, d_root} + (RSTEPS+1)'(1)) >> 1;
    for (int k = 0; k < LANES; k++) begin
      if (d_root == '0) begin
        lv[k] = !d_lane[k].nz ? '0 : (d_lane[k].neg ? VMIN : VMAX);
      end else if (d_lane[k].ovf) begin
        lv[k] = d_lane[k].neg ? VMIN : VMAX;
      end else if (d_lane[k].neg) begin
        lv[k] = ({1'b0, d_lane[k].q} > QLIM) ? VMIN : DW'(-{1'b0, d_lane[k].q});
      end else begin
        lv[k] = (d_lane[k].q > VMAX) ? VMAX : d_lane[k].q;
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (2'(c) == d_qsel) begin
        comp_nxt[c] = (qt > (RSTEPS+1)'(VMAX)) ? VMAX : DW'(qt);
      end else if (2'(c) < d_qsel) begin
        comp_nxt[c] = lv[(c < LANES) ? c : LANES - 1];
      end else begin
        comp_nxt[c] = lv[(c > 0) ? c - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_r <= comp_nxt;
    end
  end

  assign out_valid    = vld_r;
  assign out_q_scalar = $signed(comp_r[0]);
  assign out_q_x      = $signed(comp_r[1]);
  assign out_q_y      = $signed(comp_r[2]);
  assign out_q_z      = $signed(comp_r[3]);

  assign all_neg = out_q_scalar[DW-1] && out_q_x[DW-1] && out_q_y[DW-1] && out_q_z[DW-1];

  `RMQ_ASSERT_IMP(a_stall_has_result, !in_ready, out_valid, "stall without a pending result")
  `RMQ_ASSERT_IMP(a_quarter_nonneg, out_valid, !all_neg, "all components negative")
endmodule
`default_nettype wire

/* test/rmq_checker.sv */
// Checker for the rotation matrix to quaternion block: predicts each quaternion
// from the accepted matrix and compares it with the result channel.
// Depends on rmq_pkg for the data width and the fraction bits.
`timescale 1ns / 1ps
module rmq_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [rmq_pkg::DW-1:0]    r00, r10, r20, r01, r11, r21, r02, r12, r22,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [rmq_pkg::DW-1:0]    q_s, q_x, q_y, q_z,
  output int                               fails,
  output int                               pending
);
  localparam int  DW  = rmq_pkg::DW;
  localparam int  FB  = rmq_pkg::FB;
  localparam longint VMAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef struct {
    logic signed [DW-1:0] s, x, y, z;
  } quat_t;

  quat_t quat_queue[$];

  function automatic longint clamp(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint arg);
    longint unsigned x, rem, root, bitv;
    if (arg <= 0) return 0;
    x = longint'(arg) << FB;
    rem = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint quarter(input longint unsigned r);
    longint unsigned q;
    q = (r + 1) >> 1;
    if (q > VMAX) return VMAX;
    return longint'(q);
  endfunction

  function automatic longint div_root(input longint num, input longint unsigned r);
    longint unsigned mag, q;
    if (r == 0) begin
      if (num > 0) return VMAX;
      if (num < 0) return VMIN;
      return 0;
    end
    mag = num < 0 ? longint'(-num) : longint'(num);
    q = ((mag << FB) + r) / (r * 2);
    if (q > (64'd1 << DW)) q = 64'd1 << DW;
    return clamp(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t predict_quat(input longint a00, a10, a20, a01, a11, a21,
                                         a02, a12, a22);
    longint one, t, s, x, y, z;
    longint unsigned r;
    quat_t res;
    one = 64'sd1 <<< FB;
    t = one + a00 + a11 + a22;
    if (t > 1) begin
      r = root_floor(t);
      s = quarter(r);
      x = div_root(a21 - a12, r);
      y = div_root(a02 - a20, r);
      z = div_root(a10 - a01, r);
    end else if (a00 > a11 && a00 > a22) begin
      r = root_floor(one + a00 - a11 - a22);
      x = quarter(r);
      y = div_root(a10 + a01, r);
      z = div_root(a02 + a20, r);
      s = div_root(a21 - a12, r);
    end else if (a11 > a22) begin
      r = root_floor(one + a11 - a00 - a22);
      x = div_root(a10 + a01, r);
      y = quarter(r);
      z = div_root(a21 + a12, r);
      s = div_root(a02 - a20, r);
    end else begin
      r = root_floor(one + a22 - a00 - a11);
      x = div_root(a02 + a20, r);
      y = div_root(a21 + a12, r);
      z = quarter(r);
      s = div_root(a10 - a01, r);
    end
    res.s = s[DW-1:0];
    res.x = x[DW-1:0];
    res.y = y[DW-1:0];
    res.z = z[DW-1:0];
    return res;
  endfunction

  initial fails = 0;
  assign pending = quat_queue.size();

  always @(posedge clk) begin
    quat_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        quat_queue.push_back(predict_quat(r00, r10, r20, r01, r11, r21, r02, r12, r22));
      if (out_valid && out_ready) begin
        if (quat_queue.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = quat_queue.pop_front();
          if (q_s !== want.s) begin
            $error("q_scalar: expected %0d, got %0d", want.s, q_s);
            fails++;
          end
          if (q_x !== want.x) begin
            $error("q_x: expected %0d, got %0d", want.x, q_x);
            fails++;
          end
          if (q_y !== want.y) begin
            $error("q_y: expected %0d, got %0d", want.y, q_y);
            fails++;
          end
          if (q_z !== want.z) begin
            $error("q_z: expected %0d, got %0d", want.z, q_z);
            fails++;
          end
        end
      end
    end
  end
endmodule

/* test/testbench.sv */
// Top of the rotation matrix to quaternion testbench: clock, reset, matrix
// stimulus, result stalls and the verdict. Depends on rmq_checker and the block.
`timescale 1ns / 1ps
module testbench;
  localparam int DW = rmq_pkg::DW;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  logic signed [DW-1:0] mat [9];
  logic signed [DW-1:0] q_s, q_x, q_y, q_z;
  int fails, pending, cycles;
  logic done = 1'b0;

  initial for (int i = 0; i < 9; i++) mat[i] = '0;

  always #2 clk = ~clk;

  rotation_matrix_to_quaternion_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_a_r0_c0(mat[0]), .in_a_r1_c0(mat[1]), .in_a_r2_c0(mat[2]),
    .in_a_r0_c1(mat[3]), .in_a_r1_c1(mat[4]), .in_a_r2_c1(mat[5]),
    .in_a_r0_c2(mat[6]), .in_a_r1_c2(mat[7]), .in_a_r2_c2(mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_q_scalar(q_s), .out_q_x(q_x), .out_q_y(q_y), .out_q_z(q_z)
  );

  rmq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .r00(mat[0]), .r10(mat[1]), .r20(mat[2]), .r01(mat[3]), .r11(mat[4]),
    .r21(mat[5]), .r02(mat[6]), .r12(mat[7]), .r22(mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .q_s(q_s), .q_x(q_x), .q_y(q_y), .q_z(q_z),
    .fails(fails), .pending(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DW-1:0] to_fixed(input real v);
    int n;
    n = $rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5)) + $urandom_range(0, 6) - 3;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n[DW-1:0];
  endfunction

  task automatic send_request(input int m0, m1, m2, m3, m4, m5, m6, m7, m8);
    logic take;
    mat[0] <= m0[DW-1:0]; mat[1] <= m1[DW-1:0]; mat[2] <= m2[DW-1:0];
    mat[3] <= m3[DW-1:0]; mat[4] <= m4[DW-1:0]; mat[5] <= m5[DW-1:0];
    mat[6] <= m6[DW-1:0]; mat[7] <= m7[DW-1:0]; mat[8] <= m8[DW-1:0];
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      take = in_ready;
      @(posedge clk);
    end while (!take);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_rotation();
    real w, x, y, z, nrm;
    w = real'(int'($urandom_range(0, 2000)) - 1000);
    x = real'(int'($urandom_range(0, 2000)) - 1000);
    y = real'(int'($urandom_range(0, 2000)) - 1000);
    z = real'(int'($urandom_range(0, 2000)) - 1000);
    nrm = $sqrt(w * w + x * x + y * y + z * z);
    if (nrm < 1.0) begin
      w = 1.0; nrm = 1.0;
    end
    w = w / nrm; x = x / nrm; y = y / nrm; z = z / nrm;
    send_request(to_fixed(1.0 - 2.0 * (y * y + z * z)), to_fixed(2.0 * (x * y + w * z)),
                 to_fixed(2.0 * (x * z - w * y)), to_fixed(2.0 * (x * y - w * z)),
                 to_fixed(1.0 - 2.0 * (x * x + z * z)), to_fixed(2.0 * (y * z + w * x)),
                 to_fixed(2.0 * (x * z + w * y)), to_fixed(2.0 * (y * z - w * x)),
                 to_fixed(1.0 - 2.0 * (x * x + y * y)));
  endtask

  function automatic int any_word();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int diag_word();
    int p;
    p = $urandom_range(0, 3);
    if (p == 0) return -16384;
    if (p == 1) return -8192;
    if (p == 2) return 0;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  always @(posedge clk) begin
    if (rst_n && !done && $urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      repeat (gap_len() + 1) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int p, d;
    cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    send_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_request(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
    send_request(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    send_request(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    send_request(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    send_request(-16383, 100, -200, 300, 0, 400, -500, 600, 0);
    send_request(-16382, 100, -200, 300, 0, 400, -500, 600, 0);
    send_request(-8192, 50, 60, 70, -8192, 80, 90, 10, -8192);
    send_request(0, 123, 456, 789, -8192, -321, -654, -987, -8192);
    send_request(-8192, 1, 2, 3, 0, 4, 5, 6, 0);
    send_request(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
    send_request(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    send_request(32767, -32768, -32768, -32768, -32768, 32767, 32767, 32767, -32768);
    send_request(-32768, 0, 0, 0, -32768, 0, 0, 0, 32767);
    send_request(-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768, -16384);

    for (int i = 0; i < 750; i++) begin
      if (i == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      idle_sender(gap_len());
      p = $urandom_range(0, 99);
      if (p < 70) begin
        send_rotation();
      end else if (p < 85) begin
        send_request(any_word(), any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word(), any_word());
      end else begin
        d = diag_word();
        send_request(($urandom_range(0, 1) ? d : diag_word()), any_word() >>> 2,
                     any_word() >>> 2, any_word() >>> 2, d, any_word() >>> 2,
                     any_word() >>> 2, any_word() >>> 2,
                     ($urandom_range(0, 1) ? d : diag_word()));
      end
    end
    in_valid <= 1'b0;
    done <= 1'b1;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
